>>> src/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared constants, result type and CRC-16/Modbus byte step for the deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

    localparam int BUF_DEPTH_DEF = 512;

    localparam logic [7:0]  STATION_RESET = 8'h01;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic [7:0] FC_DATA_MIN = 8'd1;
    localparam logic [7:0] FC_DATA_MAX = 8'd4;

    // exception frame: address, function, exception code
    localparam logic [8:0] EXC_BODY_LEN = 9'd3;
    localparam logic [8:0] CRC_BYTES    = 9'd2;

    typedef struct packed {
        logic       found;
        logic       is_exception;
        logic [7:0] func_code;
        logic [8:0] frame_start;
        logic [8:0] frame_len;
        logic [9:0] consumed_bytes;
    } result_t;

    // one byte through the reflected CRC-16/Modbus register
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> src/modbus_rtu_response_deframer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer
// Buffers a received byte stream and reports the first response frame for
// the configured station whose CRC-16/Modbus checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte, last_byte): one byte per
//   transaction, taken at one per cycle while loading. The transaction with
//   last_byte set closes the buffer and starts the scan; in_ready stays low
//   until the scan has handed its result on. Bytes beyond BUF_DEPTH are
//   dropped, but a dropped last_byte still starts the scan.
//   Output channel (out_valid/out_ready): one result transaction per buffer.
//   found = 0 gives all-zero fields.
//   cfg_wr_en/cfg_wr_data write station_address (reset 0x01); write it only
//   while idle.
//   Scan: start offsets whose byte is not the station address are passed
//   over in turn; at a candidate the function code and length are checked,
//   then the body and CRC are read, and the scan moves on to the next
//   offset if any check fails. The scan's result is registered in the
//   output register, which drives out_valid.
//   The output register frees the scanner: loading of the next buffer goes
//   on while a result waits for out_ready; a second scan finishing before
//   then holds until the register is free.
//   Reset clears the fill count, the scanner and the output valid; the byte
//   store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module modbus_rtu_response_deframer #(
    parameter int BUF_DEPTH = mrd_pkg::BUF_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // byte input
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    // result output
    output logic       out_valid,
    input  logic       out_ready,
    output logic       found,
    output logic       is_exception,
    output logic [7:0] func_code,
    output logic [8:0] frame_start,
    output logic [8:0] frame_len,
    output logic [9:0] consumed_bytes
);

    logic [7:0]       station_reg;
    logic             res_valid;
    logic             res_ready;
    mrd_pkg::result_t res;
    logic             out_valid_reg;
    mrd_pkg::result_t out_reg;

    // station address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= mrd_pkg::STATION_RESET;
        end
        else if (cfg_wr_en)
        begin
            station_reg <= cfg_wr_data;
        end
    end

    mrd_seq #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .station   (station_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .last_byte (last_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: takes a new result in the cycle the old one leaves
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = out_reg.found;
    assign is_exception   = out_reg.is_exception;
    assign func_code      = out_reg.func_code;
    assign frame_start    = out_reg.frame_start;
    assign frame_len      = out_reg.frame_len;
    assign consumed_bytes = out_reg.consumed_bytes;

endmodule

>>> src/mrd_ram.sv
// ----------------------------------------------------------------------------
// mrd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/mrd_seq.sv
// ----------------------------------------------------------------------------
// mrd_seq
// Load and scan sequencer: fills the byte store, then walks start offsets
// reading one byte per cycle and folding the CRC as bytes arrive.
// ----------------------------------------------------------------------------
module mrd_seq #(
    parameter int BUF_DEPTH = mrd_pkg::BUF_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       station,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             last_byte,
    output logic             res_valid,
    input  logic             res_ready,
    output mrd_pkg::result_t res
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int SW = ((CW > 9) ? CW : 9) + 1;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_ADDR = 3'd1;
    localparam logic [2:0] ST_CHKA = 3'd2;
    localparam logic [2:0] ST_CHKF = 3'd3;
    localparam logic [2:0] ST_LEN  = 3'd4;
    localparam logic [2:0] ST_BODY = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] n_reg, n_next;
    logic [AW-1:0] s_reg, s_next;
    logic [8:0]    idx_reg, idx_next;
    logic [8:0]    body_end_reg, body_end_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    lo_reg, lo_next;
    logic [7:0]    code_reg, code_next;
    logic          found_reg, found_next;

    logic          ram_wr_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    logic [SW-1:0] s_ext, n_ext;
    logic [SW-1:0] flen_ext;
    logic [15:0]   crc_upd;

    assign s_ext    = SW'(s_reg);
    assign n_ext    = SW'(n_reg);
    assign crc_upd  = mrd_pkg::crc16_step(crc_reg, ram_rd_data);
    assign flen_ext = SW'(body_end_reg) + SW'(mrd_pkg::CRC_BYTES);

    mrd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        n_next        = n_reg;
        s_next        = s_reg;
        idx_next      = idx_reg;
        body_end_next = body_end_reg;
        crc_next      = crc_reg;
        lo_next       = lo_reg;
        code_next     = code_reg;
        found_next    = found_reg;
        ram_wr_en     = 1'b0;
        ram_rd_addr   = s_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (fill_reg < CW'(BUF_DEPTH))
                    begin
                        ram_wr_en = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end
                    if (last_byte)
                    begin
                        n_next     = fill_next;
                        fill_next  = '0;
                        s_next     = '0;
                        state_next = ST_ADDR;
                    end
                end
            end

            ST_ADDR:
            begin
                ram_rd_addr = s_reg;
                if (s_ext < n_ext)
                begin
                    state_next = ST_CHKA;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
            end

            // address byte arriving; next offset already requested
            ST_CHKA:
            begin
                ram_rd_addr = s_reg + AW'(1);
                if (ram_rd_data == station && s_ext + SW'(2) <= n_ext)
                begin
                    crc_next   = mrd_pkg::crc16_step(mrd_pkg::CRC_INIT, ram_rd_data);
                    state_next = ST_CHKF;
                end
                else if (s_ext + SW'(1) < n_ext)
                begin
                    s_next = s_reg + AW'(1);
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
            end

            ST_CHKF:
            begin
                ram_rd_addr = AW'(s_ext + SW'(2));
                code_next   = ram_rd_data;
                if (ram_rd_data[7] && s_ext + SW'(5) <= n_ext)
                begin
                    crc_next      = crc_upd;
                    body_end_next = mrd_pkg::EXC_BODY_LEN;
                    idx_next      = 9'd2;
                    state_next    = ST_BODY;
                end
                else if (ram_rd_data inside {[mrd_pkg::FC_DATA_MIN:mrd_pkg::FC_DATA_MAX]}
                         && s_ext + SW'(3) <= n_ext)
                begin
                    crc_next   = crc_upd;
                    state_next = ST_LEN;
                end
                else
                begin
                    s_next     = s_reg + AW'(1);
                    state_next = ST_ADDR;
                end
            end

            ST_LEN:
            begin
                ram_rd_addr = AW'(s_ext + SW'(3));
                if (s_ext + SW'(ram_rd_data) + SW'(5) <= n_ext)
                begin
                    crc_next      = crc_upd;
                    body_end_next = 9'(ram_rd_data) + 9'd3;
                    idx_next      = 9'd3;
                    state_next    = ST_BODY;
                end
                else
                begin
                    s_next     = s_reg + AW'(1);
                    state_next = ST_ADDR;
                end
            end

            // body bytes, then CRC low and high
            ST_BODY:
            begin
                ram_rd_addr = AW'(s_ext + SW'(idx_reg) + SW'(1));
                idx_next    = idx_reg + 9'd1;
                if (idx_reg < body_end_reg)
                begin
                    crc_next = crc_upd;
                end
                else if (idx_reg == body_end_reg)
                begin
                    lo_next = ram_rd_data;
                end
                else if (crc_reg == {ram_rd_data, lo_reg})
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    s_next     = s_reg + AW'(1);
                    state_next = ST_ADDR;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        if (found_reg)
        begin
            res.found          = 1'b1;
            res.is_exception   = code_reg[7];
            res.func_code      = code_reg;
            res.frame_start    = 9'(s_reg);
            res.frame_len      = 9'(flen_ext);
            res.consumed_bytes = 10'(s_ext + flen_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        s_reg        <= s_next;
        idx_reg      <= idx_next;
        body_end_reg <= body_end_next;
        crc_reg      <= crc_next;
        lo_reg       <= lo_next;
        code_reg     <= code_next;
        found_reg    <= found_next;
    end

endmodule

>>> src/mrd_chk.sv
// ----------------------------------------------------------------------------
// mrd_chk
// Port-level checks on the deframer's result transactions.
// ----------------------------------------------------------------------------
module mrd_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       found,
    input logic       is_exception,
    input logic [7:0] func_code,
    input logic [8:0] frame_start,
    input logic [8:0] frame_len,
    input logic [9:0] consumed_bytes
);

    // no frame: every field reads zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (!is_exception && func_code == 8'd0
            && frame_start == 9'd0 && frame_len == 9'd0 && consumed_bytes == 10'd0))
        else $error("non-zero fields on an empty result");

    // consumed count is start plus length
    a_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (consumed_bytes[8:0] == 9'(frame_start + frame_len)))
        else $error("consumed_bytes disagrees with start and length");

    // exception frames are five bytes with bit 7 of the code set
    a_exception: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found && is_exception) |->
            (frame_len == mrd_pkg::EXC_BODY_LEN + mrd_pkg::CRC_BYTES && func_code[7]))
        else $error("bad exception frame result");

    // data frames carry the data codes and at least five bytes
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found && !is_exception) |->
            (func_code >= mrd_pkg::FC_DATA_MIN && func_code <= mrd_pkg::FC_DATA_MAX
             && frame_len >= mrd_pkg::EXC_BODY_LEN + mrd_pkg::CRC_BYTES))
        else $error("bad data frame result");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(found)
            && $stable(frame_start) && $stable(frame_len)))
        else $error("result changed while stalled");

endmodule

bind modbus_rtu_response_deframer mrd_chk u_mrd_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .is_exception   (is_exception),
    .func_code      (func_code),
    .frame_start    (frame_start),
    .frame_len      (frame_len),
    .consumed_bytes (consumed_bytes)
);

>>> dv/modbus_rtu_response_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer_tb
// Self-checking bench for the response deframer. Byte buffers carrying
// Modbus RTU response frames (good, corrupted, truncated, foreign station,
// unsupported codes, noise) are streamed in. A predictor in the bench works
// out the reported frame of each buffer, and every result transaction is
// checked field by field against it, with random idling on both channels.
// ----------------------------------------------------------------------------
module modbus_rtu_response_deframer_tb;

    localparam int DEPTH       = mrd_pkg::BUF_DEPTH_DEF;
    localparam int ITEM_TARGET = 1350;

    // function codes used by the stimulus
    localparam logic [7:0] FC_ZERO          = 8'h00;
    localparam logic [7:0] FC_READ_COILS    = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT    = 8'h04;
    localparam logic [7:0] FC_UNSUPPORTED   = 8'h05;
    localparam logic [7:0] FC_TOP_PLAIN     = 8'h7F;
    localparam logic [7:0] FC_EXC_FLAG      = 8'h80;
    localparam logic [7:0] FC_EXC_ALL       = 8'hFF;

    typedef logic [7:0] octet_q_t[$];

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte     = 8'h00;
    logic       last_byte   = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic       found;
    logic       is_exception;
    logic [7:0] func_code;
    logic [8:0] frame_start;
    logic [8:0] frame_len;
    logic [9:0] consumed_bytes;

    modbus_rtu_response_deframer #(
        .BUF_DEPTH (DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .is_exception   (is_exception),
        .func_code      (func_code),
        .frame_start    (frame_start),
        .frame_len      (frame_len),
        .consumed_bytes (consumed_bytes)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    octet_q_t          held_bytes;              // bytes the block holds now
    octet_q_t          outgoing;                // buffer being assembled
    mrd_pkg::result_t  expected_results[$];     // one per closed buffer
    logic [7:0]        station_shadow = mrd_pkg::STATION_RESET;
    int                mismatch_count = 0;
    int                items_sent     = 0;      // input transactions so far
    bit                steady         = 1'b0;   // no idling on either side
    bit                in_offered     = 1'b0;   // in_valid as last driven
    int                sink_wait      = 0;
    int                sink_hold      = 0;
    int                sink_hold_req  = 0;      // long hold-off request

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // overall limit, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // CRC-16/Modbus: init all ones, reflected poly, bit-serial
    function automatic logic [15:0] crc16_modbus(input octet_q_t data, input int first,
                                                 input int count);
        logic [15:0] crc;
        crc = mrd_pkg::CRC_INIT;
        for (int k = 0; k < count; k++)
        begin
            crc = crc ^ {8'h00, data[first + k]};
            repeat (8)
                crc = crc[0] ? ((crc >> 1) ^ mrd_pkg::CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    // First start offset holding a whole, CRC-clean frame for the station.
    // Nothing found gives an all-zero result.
    function automatic mrd_pkg::result_t scan_for_frame(input octet_q_t held,
                                                        input logic [7:0] station);
        mrd_pkg::result_t r;
        int               n;
        int               body;
        logic [7:0]       code;
        logic [15:0]      sent_crc;
        r = '0;
        n = held.size();
        for (int s = 0; s < n; s++)
        begin
            if (held[s] != station || s + 2 > n)
                continue;
            code = held[s + 1];
            body = 0;
            if (code[7])
                body = int'(mrd_pkg::EXC_BODY_LEN);
            else if (code >= mrd_pkg::FC_DATA_MIN && code <= mrd_pkg::FC_DATA_MAX
                     && s + 3 <= n)
                body = int'(held[s + 2]) + 3;
            // other codes and partial frames are passed over
            if (body == 0 || s + body + 2 > n)
                continue;
            sent_crc = {held[s + body + 1], held[s + body]};
            if (crc16_modbus(held, s, body) == sent_crc)
            begin
                r.found          = 1'b1;
                r.is_exception   = code[7];
                r.func_code      = code;
                r.frame_start    = 9'(s);
                r.frame_len      = 9'(body + 2);
                r.consumed_bytes = 10'(s + body + 2);
                return r;
            end
        end
        return r;
    endfunction

    // Bytes past the store depth are lost; a lost closing byte still scans.
    function automatic void absorb_byte(input logic [7:0] data, input logic last);
        if (held_bytes.size() < DEPTH)
            held_bytes.push_back(data);
        if (last)
        begin
            expected_results.push_back(scan_for_frame(held_bytes, station_shadow));
            held_bytes.delete();
        end
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random pauses per transaction, plus long hold-offs
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait = 0;
            sink_hold = 0;
        end
        else
        begin
            if (sink_hold_req != 0)
            begin
                sink_hold     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (sink_hold != 0)
            begin
                sink_hold--;
                out_ready <= 1'b0;
            end
            else if (out_ready)
            begin
                // transaction completes at this edge: pick the next pause
                if (out_valid)
                begin
                    sink_wait = draw_gap();
                    if (sink_wait != 0)
                        out_ready <= 1'b0;
                end
            end
            else if (sink_wait != 0)
                sink_wait--;
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    function automatic void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
            log_mismatch($sformatf("%s: expected %0d, got %0d", name, want, got));
    endfunction

    always @(posedge clk)
    begin : result_check
        mrd_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                log_mismatch("result transaction with no buffer outstanding");
            else
            begin
                want = expected_results.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("is_exception", 32'(want.is_exception), 32'(is_exception));
                check_field("func_code", 32'(want.func_code), 32'(func_code));
                check_field("frame_start", 32'(want.frame_start), 32'(frame_start));
                check_field("frame_len", 32'(want.frame_len), 32'(frame_len));
                check_field("consumed_bytes", 32'(want.consumed_bytes),
                            32'(consumed_bytes));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side. Every call starts at a rising edge. in_valid is left
    // high after a transaction and only dropped when a pause follows, so
    // back-to-back bytes never see valid lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            if (in_offered)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        rx_byte    <= data;
        last_byte  <= last;
        in_offered = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        absorb_byte(data, last);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < outgoing.size(); i++)
            send_byte(outgoing[i], i == outgoing.size() - 1);
        outgoing.delete();
    endtask

    // Sender pauses until every result is in. Each closed buffer yields a
    // result, so an empty queue means the block is idle.
    task automatic await_results();
        if (in_offered)
        begin
            in_valid   <= 1'b0;
            in_offered = 1'b0;
        end
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_station(input logic [7:0] addr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        station_shadow = addr;
    endtask

    // ------------------------------------------------------------------
    // Buffer assembly
    // ------------------------------------------------------------------
    // Exception frames take a random exception code; every other code gets
    // a length byte and that many data bytes. A bad CRC flips 1..16 bits.
    function automatic void append_frame(input logic [7:0] addr, input logic [7:0] code,
                                         input int len, input bit crc_ok);
        int          first;
        logic [15:0] crc;
        first = outgoing.size();
        outgoing.push_back(addr);
        outgoing.push_back(code);
        if (code[7])
            outgoing.push_back(8'($urandom));
        else
        begin
            outgoing.push_back(8'(len));
            repeat (len)
                outgoing.push_back(8'($urandom));
        end
        crc = crc16_modbus(outgoing, first, outgoing.size() - first);
        if (!crc_ok)
            crc ^= 16'($urandom_range(1, 16'hFFFF));
        outgoing.push_back(crc[7:0]);
        outgoing.push_back(crc[15:8]);
    endfunction

    // noise leans towards the station address so stray candidates turn up
    function automatic void append_noise(input int count);
        repeat (count)
            outgoing.push_back(($urandom_range(0, 7) == 0) ? station_shadow
                                                           : 8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // station address straight out of reset; lone address byte finds nothing
    task automatic test_reset_station();
        append_frame(mrd_pkg::STATION_RESET, FC_READ_HOLDING, 2, 1'b1);
        send_buffer();
        outgoing.push_back(mrd_pkg::STATION_RESET);
        send_buffer();
    endtask

    task automatic test_function_codes();
        for (int c = int'(mrd_pkg::FC_DATA_MIN); c <= int'(mrd_pkg::FC_DATA_MAX); c++)
        begin
            append_noise(1);
            append_frame(station_shadow, 8'(c), c, 1'b1);
            send_buffer();
        end
        append_frame(station_shadow, FC_EXC_FLAG, 0, 1'b1);
        send_buffer();
        append_frame(station_shadow, FC_EXC_ALL, 0, 1'b1);
        send_buffer();
        // unsupported codes are skipped even with a clean CRC
        append_frame(station_shadow, FC_ZERO, 1, 1'b1);
        append_frame(station_shadow, FC_UNSUPPORTED, 0, 1'b1);
        append_frame(station_shadow, FC_TOP_PLAIN, 2, 1'b1);
        append_frame(station_shadow, FC_READ_DISCRETE, 1, 1'b1);
        send_buffer();
        // corrupted CRC passed over, next frame taken
        append_frame(station_shadow, FC_READ_COILS, 3, 1'b0);
        append_frame(station_shadow, FC_EXC_FLAG | FC_READ_INPUT, 0, 1'b1);
        send_buffer();
        // frame cut short by one byte
        append_frame(station_shadow, FC_READ_INPUT, 2, 1'b1);
        void'(outgoing.pop_back());
        send_buffer();
        // address and code only, then with a length byte but no more
        outgoing.push_back(station_shadow);
        outgoing.push_back(FC_READ_HOLDING);
        send_buffer();
        outgoing.push_back(station_shadow);
        outgoing.push_back(FC_READ_HOLDING);
        outgoing.push_back(8'h00);
        send_buffer();
        // clean frame for another station
        append_frame(station_shadow ^ 8'h01, FC_READ_HOLDING, 1, 1'b1);
        send_buffer();
    endtask

    task automatic test_station_extremes();
        await_results();
        write_station(8'h00);
        append_frame(8'h00, FC_READ_COILS, 0, 1'b1);
        send_buffer();
        await_results();
        write_station(8'hFF);
        append_frame(8'h00, FC_READ_COILS, 0, 1'b1);
        append_frame(8'hFF, FC_EXC_ALL, 0, 1'b1);
        send_buffer();
        await_results();
        write_station(mrd_pkg::STATION_RESET);
    endtask

    task automatic test_size_extremes();
        // longest data frame ends on the last store entry; the closing
        // byte beyond it is dropped but still starts the scan
        append_noise(252);
        append_frame(station_shadow, FC_READ_INPUT, 255, 1'b1);
        outgoing.push_back(8'($urandom));
        send_buffer();
        // frame straddling the end of the store, its tail dropped
        append_noise(500);
        append_frame(station_shadow, FC_READ_HOLDING, 10, 1'b1);
        send_buffer();
    endtask

    // Result side stalls for a long stretch while buffers keep coming: the
    // output register and the held scan fill, so in_ready must drop.
    task automatic test_backpressure();
        await_results();
        steady        = 1'b1;
        sink_hold_req = 600;
        repeat (5)
        begin
            append_noise(2);
            append_frame(station_shadow, FC_READ_HOLDING, 3, 1'b1);
            send_buffer();
        end
        await_results();
        steady = 1'b0;
    endtask

    // Mostly well-formed frames with random content, mixed with noise,
    // corrupted CRCs, foreign stations, unsupported codes and cut-off tails.
    // Runs until the whole test has sent its share of bytes.
    task automatic test_random_traffic();
        int         buffers;
        int         pick;
        logic [7:0] addr;
        logic [7:0] code;
        int         len;
        buffers = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (buffers % 12 == 11)
            begin
                await_results();
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_station(8'h00);
                else if (pick == 1)
                    write_station(8'hFF);
                else
                    write_station(8'($urandom));
            end
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    append_noise($urandom_range(1, 6));
                else
                begin
                    addr = station_shadow;
                    if (pick == 8)
                        addr = station_shadow ^ 8'($urandom_range(1, 255));
                    if (pick == 9)
                        code = ($urandom_range(0, 1) == 0) ? FC_ZERO
                             : 8'($urandom_range(FC_UNSUPPORTED, FC_TOP_PLAIN));
                    else if ($urandom_range(0, 9) < 7)
                        code = 8'($urandom_range(mrd_pkg::FC_DATA_MIN,
                                                 mrd_pkg::FC_DATA_MAX));
                    else
                        code = FC_EXC_FLAG | 8'($urandom);
                    // a rare long frame, mostly short ones
                    len = ($urandom_range(0, 39) == 0) ? $urandom_range(13, 255)
                                                       : $urandom_range(0, 12);
                    append_frame(addr, code, len, $urandom_range(0, 4) != 0);
                end
            end
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 4))
                    if (outgoing.size() > 1)
                        void'(outgoing.pop_back());
            buffers++;
            send_buffer();
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_station();
        test_function_codes();
        test_station_extremes();
        test_size_extremes();
        test_backpressure();
        test_random_traffic();
        await_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/mrd_pkg.sv
src/mrd_ram.sv
src/mrd_seq.sv
src/modbus_rtu_response_deframer.sv
src/mrd_chk.sv
dv/modbus_rtu_response_deframer_tb.sv
